FILE: rtl/lcs_pkg.sv
// Shared types and codes for the LCS length engine.
// Used by lcs_cell and lcs_length_engine; depends on nothing else.
package lcs_pkg;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_QUERY  = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
   localparam logic [1:0] STATUS_ORDER     = 2'd2;

   localparam int unsigned SYM_W = 8;

   // Control part of a token moving down the cell chain.
   typedef struct packed {
      logic             valid;
      logic             finish;
      logic [SYM_W-1:0] symbol;
   } tok_ctrl_type;

endpackage

FILE: rtl/lcs_cell.sv
// One cell of the systolic LCS chain: holds one reference byte and one DP entry.
// Depends on lcs_pkg for the token control struct.
module lcs_cell #(
   parameter int unsigned DW = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 ref_wr,
   input  logic [7:0]           ref_symbol,
   input  logic                 next_loaded,
   output logic                 loaded,
   input  lcs_pkg::tok_ctrl_type tok_in,
   input  logic [DW-1:0]        up_in,
   input  logic [DW-1:0]        diag_in,
   input  logic [DW-1:0]        res_in,
   output lcs_pkg::tok_ctrl_type tok_out,
   output logic [DW-1:0]        up_out,
   output logic [DW-1:0]        diag_out,
   output logic [DW-1:0]        res_out
);
   import lcs_pkg::*;

   logic            loaded_ff, loaded_in;
   logic [7:0]      ref_ff, ref_in;
   logic [DW-1:0]   dp_ff, dp_in;
   logic            tok_valid_ff;
   logic            tok_finish_ff;
   logic [SYM_W-1:0] tok_symbol_ff;
   logic [DW-1:0]   up_ff, up_in_next;
   logic [DW-1:0]   diag_ff, diag_in_next;
   logic [DW-1:0]   res_ff, res_in_next;
   logic [DW-1:0]   cell_value;

   always_comb begin
      if (ref_ff == tok_in.symbol) begin
         cell_value = diag_in + DW'(1);
      end else if (up_in > dp_ff) begin
         cell_value = up_in;
      end else begin
         cell_value = dp_ff;
      end
   end

   always_comb begin
      loaded_in    = loaded_ff;
      ref_in       = ref_ff;
      dp_in        = dp_ff;
      up_in_next   = up_in;
      diag_in_next = diag_in;
      res_in_next  = res_in;
      if (ref_wr) begin
         loaded_in = 1'b1;
         ref_in    = ref_symbol;
      end
      if (tok_in.valid && tok_in.finish) begin
         // The last loaded cell drops its entry into the passing result.
         if (loaded_ff && !next_loaded) begin
            res_in_next = dp_ff;
         end
         loaded_in = 1'b0;
         dp_in     = '0;
      end else if (tok_in.valid && loaded_ff) begin
         dp_in        = cell_value;
         up_in_next   = cell_value;
         diag_in_next = dp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= 1'b0;
         dp_ff        <= '0;
         tok_valid_ff <= 1'b0;
      end else begin
         loaded_ff    <= loaded_in;
         dp_ff        <= dp_in;
         tok_valid_ff <= tok_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      ref_ff        <= ref_in;
      tok_finish_ff <= tok_in.finish;
      tok_symbol_ff <= tok_in.symbol;
      up_ff         <= up_in_next;
      diag_ff       <= diag_in_next;
      res_ff        <= res_in_next;
   end

   assign loaded   = loaded_ff;
   assign tok_out  = {tok_valid_ff, tok_finish_ff, tok_symbol_ff};
   assign up_out   = up_ff;
   assign diag_out = diag_ff;
   assign res_out  = res_ff;

endmodule

FILE: rtl/lcs_length_engine.sv
// Top level of the LCS length engine: control registers, the cell chain and the
// result register. Depends on lcs_pkg and lcs_cell.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | req_kind, req_symbol
//   rsp     | out       | rsp_valid/stall   | rsp_lcs_length, rsp_status
//
// Load and query words are taken one per cycle while req_stall is low; a query
// moves down the chain one cell per cycle, so queries overlap as a wavefront.
// A finish word follows the queries down the chain; its result is registered
// once the finish token leaves the last cell.
// From a finish word until its result word is taken, req_stall stays high.
// Reset clears the counts, flags, cell valid bits and DP entries; reference
// bytes are not reset.
module lcs_length_engine #(
   parameter int unsigned MAX_LEN = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_symbol,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_lcs_length,
   output logic [1:0] rsp_status
);
   import lcs_pkg::*;

   localparam int unsigned DW = $clog2(MAX_LEN + 1);
   localparam int unsigned EW = (DW > 7) ? DW : 7;

   logic            req_accept, rsp_accept;
   logic [DW-1:0]   ref_count_ff, ref_count_in;
   logic            query_started_ff, query_started_in;
   logic [1:0]      error_ff, error_in;
   logic [1:0]      status_ff, status_in;
   logic            busy_ff, busy_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [6:0]      rsp_len_ff, rsp_len_in;
   logic [1:0]      rsp_status_ff;
   logic            load_ok;
   logic [EW-1:0]   res_ext;

   tok_ctrl_type    tok_w  [0:MAX_LEN];
   logic [DW-1:0]   up_w   [0:MAX_LEN];
   logic [DW-1:0]   diag_w [0:MAX_LEN];
   logic [DW-1:0]   res_w  [0:MAX_LEN];
   logic            loaded_w [0:MAX_LEN];

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = busy_ff;

   assign load_ok = req_accept && (req_kind == KIND_LOAD) && !query_started_ff &&
                    (ref_count_ff < DW'(MAX_LEN));

   always_comb begin
      ref_count_in     = ref_count_ff;
      query_started_in = query_started_ff;
      error_in         = error_ff;
      status_in        = status_ff;
      busy_in          = busy_ff;
      if (req_accept) begin
         unique case (req_kind)
            KIND_LOAD: begin
               if (query_started_ff) begin
                  error_in = STATUS_ORDER;
               end else if (ref_count_ff >= DW'(MAX_LEN)) begin
                  if (error_ff != STATUS_ORDER) begin
                     error_in = STATUS_TRUNCATED;
                  end
               end else begin
                  ref_count_in = ref_count_ff + DW'(1);
               end
            end
            KIND_QUERY: begin
               query_started_in = 1'b1;
            end
            KIND_FINISH: begin
               status_in        = error_ff;
               ref_count_in     = '0;
               query_started_in = 1'b0;
               error_in         = STATUS_OK;
               busy_in          = 1'b1;
            end
            default: begin
            end
         endcase
      end
      if (rsp_accept) begin
         busy_in = 1'b0;
      end
   end

   // Tokens enter the first cell straight from the accepted request word.
   assign tok_w[0].valid  = req_accept &&
                            ((req_kind == KIND_QUERY) || (req_kind == KIND_FINISH));
   assign tok_w[0].finish = (req_kind == KIND_FINISH);
   assign tok_w[0].symbol = req_symbol;
   assign up_w[0]         = '0;
   assign diag_w[0]       = '0;
   assign res_w[0]        = '0;
   assign loaded_w[MAX_LEN] = 1'b0;

   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      lcs_cell #(
         .DW(DW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ref_wr      (load_ok && (ref_count_ff == DW'(i))),
         .ref_symbol  (req_symbol),
         .next_loaded (loaded_w[i+1]),
         .loaded      (loaded_w[i]),
         .tok_in      (tok_w[i]),
         .up_in       (up_w[i]),
         .diag_in     (diag_w[i]),
         .res_in      (res_w[i]),
         .tok_out     (tok_w[i+1]),
         .up_out      (up_w[i+1]),
         .diag_out    (diag_w[i+1]),
         .res_out     (res_w[i+1])
      );
   end

   assign res_ext = EW'(res_w[MAX_LEN]);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_len_in   = rsp_len_ff;
      if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
      if (tok_w[MAX_LEN].valid && tok_w[MAX_LEN].finish) begin
         rsp_valid_in = 1'b1;
         rsp_len_in   = (res_ext > EW'(127)) ? 7'd127 : res_ext[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_count_ff     <= '0;
         query_started_ff <= 1'b0;
         error_ff         <= STATUS_OK;
         busy_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         ref_count_ff     <= ref_count_in;
         query_started_ff <= query_started_in;
         error_ff         <= error_in;
         busy_ff          <= busy_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rsp_len_ff <= rsp_len_in;
      if (tok_w[MAX_LEN].valid && tok_w[MAX_LEN].finish) begin
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lcs_length = rsp_len_ff;
   assign rsp_status     = rsp_status_ff;

   // A result word only exists while a finish is outstanding.
   a_rsp_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> busy_ff)
      else $error("result word without an outstanding finish");

   // A finish token never leaves the chain while no finish is outstanding.
   a_tok_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (tok_w[MAX_LEN].valid && tok_w[MAX_LEN].finish) |-> (busy_ff && !rsp_valid_ff))
      else $error("finish token left the chain unexpectedly");

   // A reference byte after a query is always flagged as an order error.
   a_order_error: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_kind == KIND_LOAD) && query_started_ff)
      |=> (error_ff == STATUS_ORDER))
      else $error("late reference byte not flagged");

   // While a finish drains, the reference count stays cleared.
   a_drain_cleared: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ((ref_count_ff == '0) && !query_started_ff))
      else $error("control state changed while draining");

endmodule
